FILE: hdl/brute_force_substring_search_top_defines.svh
// Assertion helpers for the checker file of the search block.
`ifndef BRUTE_FORCE_SUBSTRING_SEARCH_TOP_DEFINES_SVH
`define BRUTE_FORCE_SUBSTRING_SEARCH_TOP_DEFINES_SVH

// Sampling event used by every assertion of the block.
`define BFSS_CLK @(posedge clk)

// Implication into the next cycle, switched off while reset is applied.
`define BFSS_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (`BFSS_CLK disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

// Implication within the same cycle, switched off while reset is applied.
`define BFSS_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (`BFSS_CLK disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

FILE: hdl/bfss_pkg.sv
`timescale 1ns / 1ps

package bfss_pkg;

	// Operation codes carried by an input word.
	typedef enum logic [1:0] {
		OP_TEXT    = 2'd0,
		OP_PATTERN = 2'd1,
		OP_SEARCH  = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	// Input word.
	typedef struct packed {
		op_t        op;
		logic [7:0] data_byte;
		logic [7:0] start_pos;
	} cmd_word_t;

	// Result word.
	typedef struct packed {
		logic [7:0] match_pos;
		logic       store_full;
	} res_word_t;

	// Source of a search result.
	typedef enum logic [1:0] {
		RES_START = 2'd0,
		RES_ZERO  = 2'd1,
		RES_HIT   = 2'd2
	} res_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     accept;
		logic     start;
		logic     rd_cur;
		logic     rd_step;
		logic     retry;
		logic     res_load;
		res_sel_t sel;
		logic     out_load;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pat_empty;
		logic no_room;
		logic eq;
		logic last;
	} stat_t;

endpackage

FILE: hdl/bfss_dp.sv
`timescale 1ns / 1ps

module bfss_dp import bfss_pkg::*; #(
	parameter int MAX_LEN = 255
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_word_t cmd,
	input  ctl_t      ctl,
	output stat_t     stat,
	output res_word_t res
);

	localparam int LEN_W  = $clog2(MAX_LEN + 1);
	localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int POS_W  = ((LEN_W > 8) ? LEN_W : 8) + 1;
	localparam int SUM_W  = POS_W + 1;

	logic [7:0]       text_mem [MAX_LEN];
	logic [7:0]       pat_mem  [MAX_LEN];
	logic [LEN_W-1:0] tlen_q;
	logic [LEN_W-1:0] plen_q;
	logic             ovf_q;
	logic [POS_W-1:0] s_q;
	logic [LEN_W-1:0] k_q;
	logic [7:0]       tdata_q;
	logic [7:0]       pdata_q;
	res_word_t        hold_q;
	res_word_t        out_q;

	logic             text_full;
	logic             pat_full;
	logic             rd_en;
	logic [LEN_W-1:0] rd_k;
	logic [POS_W-1:0] taddr_full;
	logic [7:0]       start_eff;

	assign text_full  = (tlen_q == LEN_W'(MAX_LEN));
	assign pat_full   = (plen_q == LEN_W'(MAX_LEN));
	assign rd_en      = ctl.rd_cur | ctl.rd_step;
	assign rd_k       = ctl.rd_step ? (k_q + LEN_W'(1)) : k_q;
	assign taddr_full = s_q - POS_W'(1) + POS_W'(rd_k);
	assign start_eff  = (cmd.start_pos == 8'd0) ? 8'd1 : cmd.start_pos;

	// Text store: appended while idle, read a byte at a time while searching.
	always_ff @(posedge clk) begin
		if (ctl.accept && cmd.op == OP_TEXT && !text_full) begin
			text_mem[tlen_q[ADDR_W-1:0]] <= cmd.data_byte;
		end
		if (rd_en) begin
			tdata_q <= text_mem[taddr_full[ADDR_W-1:0]];
		end
	end

	// Pattern store, same arrangement.
	always_ff @(posedge clk) begin
		if (ctl.accept && cmd.op == OP_PATTERN && !pat_full) begin
			pat_mem[plen_q[ADDR_W-1:0]] <= cmd.data_byte;
		end
		if (rd_en) begin
			pdata_q <= pat_mem[rd_k[ADDR_W-1:0]];
		end
	end

	// Lengths and the sticky overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlen_q <= '0;
			plen_q <= '0;
			ovf_q  <= 1'b0;
		end else if (ctl.accept) begin
			unique case (cmd.op)
				OP_TEXT: begin
					if (text_full) ovf_q <= 1'b1;
					else tlen_q <= tlen_q + LEN_W'(1);
				end
				OP_PATTERN: begin
					if (pat_full) ovf_q <= 1'b1;
					else plen_q <= plen_q + LEN_W'(1);
				end
				OP_SEARCH: begin
				end
				OP_CLEAR: begin
					tlen_q <= '0;
					plen_q <= '0;
					ovf_q  <= 1'b0;
				end
			endcase
		end
	end

	// Alignment and character counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q <= '0;
			k_q <= '0;
		end else if (ctl.start) begin
			s_q <= POS_W'(start_eff);
			k_q <= '0;
		end else if (ctl.retry) begin
			s_q <= s_q + POS_W'(1);
			k_q <= '0;
		end else if (ctl.rd_step) begin
			k_q <= k_q + LEN_W'(1);
		end
	end

	// Finished result, then the output word held for the receiver.
	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			hold_q.store_full <= ovf_q;
			unique case (ctl.sel)
				RES_START: hold_q.match_pos <= start_eff;
				RES_HIT:   hold_q.match_pos <= s_q[7:0];
				default:   hold_q.match_pos <= 8'd0;
			endcase
		end
		if (ctl.out_load) begin
			out_q <= hold_q;
		end
	end

	// The last alignment that fits ends at the last text byte.
	assign stat.no_room   = (SUM_W'(s_q) + SUM_W'(plen_q)) > (SUM_W'(tlen_q) + SUM_W'(1));
	assign stat.pat_empty = (plen_q == '0);
	assign stat.eq        = (tdata_q == pdata_q);
	assign stat.last      = ((k_q + LEN_W'(1)) == plen_q);
	assign res            = out_q;

endmodule

FILE: hdl/bfss_ctrl.sv
`timescale 1ns / 1ps

module bfss_ctrl import bfss_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cmd_valid,
	input  op_t   op,
	output logic  cmd_ready,
	input  logic  res_ready,
	output logic  res_valid,
	input  stat_t stat,
	output ctl_t  ctl
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_BOUND = 4'b0010,
		ST_CMP   = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign cmd_ready = (state_q == ST_IDLE);
	assign res_valid = out_valid_q;

	// Next state and datapath commands.
	always_comb begin
		state_d      = state_q;
		ctl          = '0;
		ctl.sel      = RES_ZERO;
		ctl.accept   = cmd_valid && (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (ctl.accept && op == OP_SEARCH) begin
					if (stat.pat_empty) begin
						ctl.res_load = 1'b1;
						ctl.sel      = RES_START;
						state_d      = ST_DONE;
					end else begin
						ctl.start = 1'b1;
						state_d   = ST_BOUND;
					end
				end
			end
			ST_BOUND: begin
				if (stat.no_room) begin
					ctl.res_load = 1'b1;
					ctl.sel      = RES_ZERO;
					state_d      = ST_DONE;
				end else begin
					ctl.rd_cur = 1'b1;
					state_d    = ST_CMP;
				end
			end
			ST_CMP: begin
				if (!stat.eq) begin
					ctl.retry = 1'b1;
					state_d   = ST_BOUND;
				end else if (stat.last) begin
					ctl.res_load = 1'b1;
					ctl.sel      = RES_HIT;
					state_d      = ST_DONE;
				end else begin
					ctl.rd_step = 1'b1;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || res_ready) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) out_valid_q <= 1'b1;
			else if (res_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: hdl/brute_force_substring_search_top.sv
`timescale 1ns / 1ps
// Brute-force substring search over a stored text and pattern.
// Input channel cmd (valid/ready) carries one word: append a byte to the text,
// append a byte to the pattern, clear both, or search from a 1-based start.
// Output channel res (valid/ready) carries one word per search: the 1-based
// position of the first match at or after the start (0 if none) and a flag
// that is set when an append was dropped since the last clear.
// Appends and clears produce no word, so a byte stream is taken at one word
// per cycle while no search holds the block.
// A search tries one alignment at a time: it first checks that the alignment
// still fits, then compares the bytes in order and moves on at a mismatch.
// A search ends at a match, when no alignment fits any more (result 0), or at
// once for an empty pattern, which returns the start position.
// cmd_ready is low while a search runs and while its result waits in a holding
// register behind a word stalled at the output; once the result reaches the
// output register, appends and clears are taken while the receiver stalls.
// Reset clears both lengths, the overflow flag and the output valid; stored
// bytes keep whatever they held and are unreadable until written again.

module brute_force_substring_search_top import bfss_pkg::*; #(
	parameter int MAX_LEN = 255
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_word_t cmd,
	output logic      res_valid,
	input  logic      res_ready,
	output res_word_t res
);

	ctl_t  ctl;
	stat_t stat;

	// Sequencer for loads and the search loop.
	bfss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.op        (cmd.op),
		.cmd_ready (cmd_ready),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.stat      (stat),
		.ctl       (ctl)
	);

	// Stores, counters and result registers.
	bfss_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ctl    (ctl),
		.stat   (stat),
		.res    (res)
	);

endmodule

FILE: hdl/bfss_chk.sv
`timescale 1ns / 1ps
`include "brute_force_substring_search_top_defines.svh"

module bfss_chk import bfss_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      cmd_valid,
	input logic      cmd_ready,
	input cmd_word_t cmd,
	input logic      res_valid,
	input logic      res_ready,
	input res_word_t res
);

	// A stalled result word stays put.
	`BFSS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "result word changed while stalled")

	// The block is ready again in the cycle after an append or clear.
	`BFSS_ASSERT_NEXT(a_load_one_cycle, cmd_valid && cmd_ready && cmd.op != OP_SEARCH, cmd_ready, "load did not finish in one cycle")

	// A search leaves the block busy once it is accepted.
	`BFSS_ASSERT_NEXT(a_search_busy, cmd_valid && cmd_ready && cmd.op == OP_SEARCH, !cmd_ready, "block ready right after accepting a search")

	// Appends and clears never produce a result word.
	`BFSS_ASSERT_NEXT(a_load_no_result, cmd_valid && cmd_ready && cmd.op != OP_SEARCH && !res_valid, !res_valid, "result word after a load")

	// A result word on offer carries known bits.
	`BFSS_ASSERT_NOW(a_res_known, res_valid, !$isunknown(res), "result word has unknown bits")

endmodule

bind brute_force_substring_search_top bfss_chk u_chk (.*);
